[rtl/core/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and codes for the LIFO stack with reverse and sort.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

	// default geometry
	localparam int DEF_DEPTH = 16;
	localparam int DEF_WIDTH = 32;

	// request codes
	typedef enum logic [2:0] {
		REQ_PUSH    = 3'd0,
		REQ_POP     = 3'd1,
		REQ_PEEK    = 3'd2,
		REQ_REVERSE = 3'd3,
		REQ_SORT    = 3'd4
	} req_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle cell operation
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_TAG,
		CELL_SWAP
	} cell_op_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t op;
		logic     sort_mode;  // 1: compare values, 0: compare position tags
		logic     parity;     // which pairs exchange in this round
	} cell_cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/core/stk_if.sv]
// ----------------------------------------------------------------------------
// stk_if
// Request and response channels of the stack: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_req_if #(
	parameter int WIDTH = stk_pkg::DEF_WIDTH
);
	logic                    valid;
	logic                    ready;
	logic [2:0]              req_type;
	logic signed [WIDTH-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface stk_rsp_if #(
	parameter int WIDTH = stk_pkg::DEF_WIDTH,
	parameter int CNT_W = $clog2(stk_pkg::DEF_DEPTH + 1)
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] read_value;
	logic [1:0]              status;
	logic [CNT_W-1:0]        entry_count;

	modport source (output valid, output read_value, output status, output entry_count,
		input ready);
	modport sink   (input valid, input read_value, input status, input entry_count,
		output ready);
endinterface

`default_nettype wire

[rtl/core/stack_with_reverse_and_sort.sv]
// ----------------------------------------------------------------------------
// stack_with_reverse_and_sort
// LIFO stack of signed words built as a row of shifting cells, with
// in-place reverse and ascending sort by odd-even transposition.
//
// Push, pop, peek and unknown requests: the response is registered on accept.
// Reverse and sort: DEPTH exchange rounds of the cell row, then the response;
// no new request is taken meanwhile.
// Reset clears the entry count and the response valid; slot contents are
// left undefined and never read above the count.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_reverse_and_sort #(
	parameter int DEPTH = stk_pkg::DEF_DEPTH,
	parameter int WIDTH = stk_pkg::DEF_WIDTH
) (
	input  wire      clk,
	input  wire      arst_n,
	stk_req_if.sink  req,
	stk_rsp_if.source rsp
);
	import stk_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TAG_W = $clog2(DEPTH);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [TAG_W-1:0]        round_q, round_d;
	logic                    mode_q, mode_d;
	cell_cmd_t               cmd;
	logic                    acc;
	logic                    load_out;
	logic signed [WIDTH-1:0] res_val;
	status_t                 res_status;

	logic                    out_valid_q;
	logic signed [WIDTH-1:0] out_val_q;
	logic [1:0]              out_status_q;
	logic [CNT_W-1:0]        out_cnt_q;

	logic signed [WIDTH-1:0] cell_val [DEPTH];
	logic [TAG_W-1:0]        cell_tag [DEPTH];

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WIDTH-1:0] up_val, dn_val;
		logic [TAG_W-1:0]        up_tag, dn_tag;
		logic                    up_en, dn_en;

		if (i == 0) begin : g_top
			assign up_val = req.push_value;
			assign up_tag = '0;
			assign up_en  = 1'b0;
		end else begin : g_mid
			assign up_val = cell_val[i-1];
			assign up_tag = cell_tag[i-1];
			assign up_en  = (CNT_W'(i) < cnt_q);
		end

		if (i == DEPTH - 1) begin : g_bot
			assign dn_val = cell_val[i];
			assign dn_tag = cell_tag[i];
			assign dn_en  = 1'b0;
		end else begin : g_nbot
			assign dn_val = cell_val[i+1];
			assign dn_tag = cell_tag[i+1];
			assign dn_en  = (CNT_W'(i + 1) < cnt_q);
		end

		stk_cell #(
			.WIDTH (WIDTH),
			.TAG_W (TAG_W),
			.IDX   (i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.up_val (up_val),
			.up_tag (up_tag),
			.up_en  (up_en),
			.dn_val (dn_val),
			.dn_tag (dn_tag),
			.dn_en  (dn_en),
			.val    (cell_val[i]),
			.tag    (cell_tag[i])
		);
	end

	// request handshake
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	// sequencer: next state, cell command, response
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		round_d       = round_q;
		mode_d        = mode_q;
		cmd.op        = CELL_HOLD;
		cmd.sort_mode = mode_q;
		cmd.parity    = round_q[0];
		load_out      = 1'b0;
		res_val       = '0;
		res_status    = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					load_out = 1'b1;
					case (req.req_type)
						REQ_PUSH: begin
							if (cnt_q == CNT_W'(DEPTH)) begin
								res_status = ST_FULL;
							end else begin
								cmd.op = CELL_PUSH;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						REQ_POP: begin
							if (cnt_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								cmd.op  = CELL_POP;
								res_val = cell_val[0];
								cnt_d   = cnt_q - 1'b1;
							end
						end
						REQ_PEEK: begin
							if (cnt_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								res_val = cell_val[0];
							end
						end
						REQ_REVERSE: begin
							load_out = 1'b0;
							cmd.op   = CELL_TAG;
							mode_d   = 1'b0;
							round_d  = '0;
							state_d  = S_RUN;
						end
						REQ_SORT: begin
							load_out = 1'b0;
							mode_d   = 1'b1;
							round_d  = '0;
							state_d  = S_RUN;
						end
						default: ;
					endcase
				end
			end
			S_RUN: begin
				cmd.op  = CELL_SWAP;
				round_d = round_q + 1'b1;
				if (round_q == TAG_W'(DEPTH - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			round_q     <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			round_q <= round_d;
			mode_q  <= mode_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q    <= res_val;
			out_status_q <= res_status;
			out_cnt_q    <= cnt_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_val_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

`default_nettype wire

[rtl/core/stk_cell.sv]
// ----------------------------------------------------------------------------
// stk_cell
// One stack slot. Shifts with push/pop and does odd-even compare-exchange
// with a neighbor for reverse (by position tag) and sort (by value).
// Cell 0 is the top of the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cell #(
	parameter int WIDTH = stk_pkg::DEF_WIDTH,
	parameter int TAG_W = 4,
	parameter int IDX   = 0
) (
	input  wire                    clk,
	input  stk_pkg::cell_cmd_t     cmd,
	input  wire signed [WIDTH-1:0] up_val,   // from cell above (push data at top)
	input  wire [TAG_W-1:0]        up_tag,
	input  wire                    up_en,    // pair with cell above is in range
	input  wire signed [WIDTH-1:0] dn_val,   // from cell below
	input  wire [TAG_W-1:0]        dn_tag,
	input  wire                    dn_en,    // pair with cell below is in range
	output logic signed [WIDTH-1:0] val,
	output logic [TAG_W-1:0]       tag
);
	import stk_pkg::*;

	localparam logic [TAG_W-1:0] MY_TAG    = TAG_W'(IDX);
	localparam logic             MY_PARITY = 1'(IDX % 2);

	logic signed [WIDTH-1:0] val_q;
	logic [TAG_W-1:0]        tag_q;
	logic                    take_up;
	logic                    take_dn;

	// less-than on the active key
	function automatic logic key_lt(input logic signed [WIDTH-1:0] av,
		input logic [TAG_W-1:0] at, input logic signed [WIDTH-1:0] bv,
		input logic [TAG_W-1:0] bt, input logic by_val);
		key_lt = by_val ? (av < bv) : (at < bt);
	endfunction

	// exchange decision: larger key moves toward the top
	always_comb begin
		take_dn = 1'b0;
		take_up = 1'b0;
		if (MY_PARITY == cmd.parity) begin
			take_dn = dn_en && key_lt(val_q, tag_q, dn_val, dn_tag, cmd.sort_mode);
		end else begin
			take_up = up_en && key_lt(up_val, up_tag, val_q, tag_q, cmd.sort_mode);
		end
	end

	// slot register
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_PUSH: begin
				val_q <= up_val;
				tag_q <= up_tag;
			end
			CELL_POP: begin
				val_q <= dn_val;
				tag_q <= dn_tag;
			end
			CELL_TAG: tag_q <= MY_TAG;
			CELL_SWAP: begin
				if (take_dn) begin
					val_q <= dn_val;
					tag_q <= dn_tag;
				end else if (take_up) begin
					val_q <= up_val;
					tag_q <= up_tag;
				end
			end
			default: ;
		endcase
	end

	assign val = val_q;
	assign tag = tag_q;

endmodule

`default_nettype wire

[dv/tb_stack_with_reverse_and_sort.sv]
// ----------------------------------------------------------------------------
// tb_stack_with_reverse_and_sort
// Self-checking bench for the LIFO stack: a directed table covers empty,
// full, single-entry, duplicate and extreme-value cases, then phases of
// random traffic (push-heavy, pop-heavy and mixed) run against a shadow
// stack. Both channels idle at random; one long response stall backs the
// block up and the sender drains the pipe now and then.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_with_reverse_and_sort;

	import stk_pkg::*;

	localparam int DEPTH = DEF_DEPTH;
	localparam int W     = DEF_WIDTH;
	localparam int CW    = $clog2(DEF_DEPTH + 1);

	localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WORD_ZERO = '0;
	localparam logic [W-1:0] WORD_ONES = '1;

	// request codes the block ignores
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RND_ITEMS   = 1700;
	localparam int HOLD_AT     = 400;   // response index where the long stall starts
	localparam int HOLD_CYCLES = 150;
	localparam int IDLE_LIMIT  = 1000;  // cycles with no word moving on either side
	localparam int TAIL_CYCLES = DEPTH + 4;
	localparam int DIR_N       = 30;

	typedef struct packed {
		logic [W-1:0]  value;
		logic [1:0]    status;
		logic [CW-1:0] count;
	} stk_result_t;

	typedef struct packed {
		logic [2:0]    op;
		logic [W-1:0]  arg;
		logic          fixed;        // typed-in result below is used as-is
		logic [W-1:0]  want_value;
		logic [1:0]    want_status;
		logic [CW-1:0] want_count;
	} dir_row_t;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

	logic clk;
	logic arst_n;

	stk_req_if #(.WIDTH(W)) req_ch ();
	stk_rsp_if #(.WIDTH(W), .CNT_W(CW)) rsp_ch ();

	stack_with_reverse_and_sort #(
		.DEPTH(DEPTH),
		.WIDTH(W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow stack, slot 0 is the bottom
	logic [W-1:0] shadow_slot [DEPTH];
	int           shadow_fill;

	stk_result_t  result_q [$];
	int           mismatches;
	int           idle_cycles;
	int           rsp_seen;
	bit           tx_fast;
	bit           rx_fast;
	bit           rx_holding;

	// side info riding along with the request word
	logic         drv_fixed;
	stk_result_t  drv_want;

	// directed table: empty, unknown, single entry, fill to full, duplicates
	dir_row_t dir_tab [DIR_N] = '{
		'{REQ_POP,     WORD_ZERO,     1'b1, WORD_ZERO, ST_EMPTY, 5'd0},
		'{REQ_PEEK,    WORD_ONES,     1'b1, WORD_ZERO, ST_EMPTY, 5'd0},
		'{REQ_REVERSE, WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_SORT,    WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd0},
		'{OP_SPARE_HI, WORD_ONES,     1'b1, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_MIN,      1'b1, WORD_ZERO, ST_OK,    5'd1},
		'{REQ_SORT,    WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd1},
		'{REQ_REVERSE, WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd1},
		'{REQ_PEEK,    WORD_ZERO,     1'b1, WORD_MIN,  ST_OK,    5'd1},
		'{REQ_PUSH,    WORD_MAX,      1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_MAX,      1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_ZERO,     1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_ONES,     1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h0000_0001, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_ZERO,     1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h1234_5678, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'hedcb_a987, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h5555_5555, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'haaaa_aaaa, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'hffff_fffe, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h0000_0002, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h8000_0001, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    32'h7fff_fffe, 1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_MIN,      1'b0, WORD_ZERO, ST_OK,    5'd0},
		'{REQ_PUSH,    WORD_ONES,     1'b1, WORD_ZERO, ST_FULL,  5'd16},
		'{REQ_SORT,    WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd16},
		'{REQ_PEEK,    WORD_ZERO,     1'b1, WORD_MAX,  ST_OK,    5'd16},
		'{REQ_REVERSE, WORD_ZERO,     1'b1, WORD_ZERO, ST_OK,    5'd16},
		'{REQ_PEEK,    WORD_ZERO,     1'b1, WORD_MIN,  ST_OK,    5'd16},
		'{REQ_POP,     WORD_ZERO,     1'b1, WORD_MIN,  ST_OK,    5'd15}
	};

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// apply one request to the shadow stack and return its response
	function automatic stk_result_t apply_request(input logic [2:0] op,
		input logic [W-1:0] arg);
		stk_result_t  r;
		logic [W-1:0] key;
		int           lo;
		int           hi;
		int           j;
		r = '0;
		r.status = ST_OK;
		case (op)
			REQ_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_slot[shadow_fill] = arg;
					shadow_fill++;
				end
			end
			REQ_POP: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					shadow_fill--;
					r.value = shadow_slot[shadow_fill];
				end
			end
			REQ_PEEK: begin
				if (shadow_fill == 0)
					r.status = ST_EMPTY;
				else
					r.value = shadow_slot[shadow_fill - 1];
			end
			REQ_REVERSE: begin
				lo = 0;
				hi = shadow_fill - 1;
				while (lo < hi) begin
					key = shadow_slot[lo];
					shadow_slot[lo] = shadow_slot[hi];
					shadow_slot[hi] = key;
					lo++;
					hi--;
				end
			end
			REQ_SORT: begin
				// insertion sort, signed, ascending toward the top
				for (int i = 1; i < shadow_fill; i++) begin
					key = shadow_slot[i];
					j = i;
					while (j > 0 && $signed(shadow_slot[j - 1]) > $signed(key)) begin
						shadow_slot[j] = shadow_slot[j - 1];
						j--;
					end
					shadow_slot[j] = key;
				end
			end
			default: ;
		endcase
		r.count = CW'(shadow_fill);
		return r;
	endfunction

	// push-heavy, pop-heavy or mixed request mix
	function automatic logic [2:0] pick_op(input phase_kind_t kind);
		int roll;
		int push_pct;
		int pop_pct;
		case (kind)
			PH_FILL: begin
				push_pct = 70;
				pop_pct  = 10;
			end
			PH_DRAIN: begin
				push_pct = 15;
				pop_pct  = 60;
			end
			default: begin
				push_pct = 40;
				pop_pct  = 30;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return REQ_PUSH;
		if (roll < push_pct + pop_pct)
			return REQ_POP;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			return REQ_PEEK;
		if (roll < 65)
			return REQ_REVERSE;
		if (roll < 94)
			return REQ_SORT;
		return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// full-range, small (for repeats) or extreme values
	function automatic logic [W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return W'($urandom);
		if (roll < 80)
			return W'(int'($urandom_range(0, 8)) - 4);
		case ($urandom_range(0, 3))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_ZERO;
			default: return WORD_ONES;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [W-1:0] want,
		input logic [W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, $signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// offer one request word after a random gap, hold until taken
	task automatic send_word(input logic [2:0] op, input logic [W-1:0] arg,
		input logic fixed, input stk_result_t want);
		int gap;
		gap = (tx_fast || rx_holding) ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= op;
		req_ch.push_value <= arg;
		drv_fixed         <= fixed;
		drv_want          <= want;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// stop offering until every response is back
	task automatic drain_wait();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (result_q.size() == 0);
		@(posedge clk);
	endtask

	// predict on request accept, compare on response accept
	always @(posedge clk) begin
		stk_result_t want;
		bit          moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				want = apply_request(req_ch.req_type, req_ch.push_value);
				if (drv_fixed)
					want = drv_want;
				result_q.push_back(want);
				moved = 1'b1;
			end
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				moved = 1'b1;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
						$time, $signed(rsp_ch.read_value), rsp_ch.status,
						rsp_ch.entry_count);
					mismatches++;
				end else begin
					want = result_q.pop_front();
					check_field("read_value", want.value, rsp_ch.read_value);
					check_field("status", W'(want.status), W'(rsp_ch.status));
					check_field("entry_count", W'(want.count), W'(rsp_ch.entry_count));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("tb_stack_with_reverse_and_sort failed");
		$finish;
	end

	// response side: random back-pressure, one long stall
	initial begin : rsp_sink
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_seen % 64 == 0)
				rx_fast = ($urandom_range(0, 3) == 0);
			if (rsp_seen == HOLD_AT) begin
				rx_holding = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_fast ? 0 : $urandom_range(0, 15);
			end
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx_holding = 1'b0;
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			rsp_seen++;
		end
	end

	// request side and run control
	initial begin : req_source
		phase_kind_t kind;
		logic [2:0]  op;
		int          rnd_items;
		int          phase_no;
		int          len;
		mismatches  = 0;
		idle_cycles = 0;
		rsp_seen    = 0;
		rnd_items   = 0;
		phase_no    = 0;
		tx_fast     = 1'b0;
		rx_fast     = 1'b0;
		rx_holding  = 1'b0;
		shadow_fill = 0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_PUSH;
		req_ch.push_value <= '0;
		drv_fixed         <= 1'b0;
		drv_want          <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].arg, dir_tab[i].fixed,
				'{dir_tab[i].want_value, dir_tab[i].want_status, dir_tab[i].want_count});
		drain_wait();

		// random phases
		while (rnd_items < RND_ITEMS) begin
			kind    = phase_kind_t'($urandom_range(0, 2));
			tx_fast = ($urandom_range(0, 3) == 0);
			len     = $urandom_range(20, 60);
			for (int k = 0; k < len; k++) begin
				op = pick_op(kind);
				send_word(op, pick_value(), 1'b0, '0);
				if (op <= REQ_SORT)
					rnd_items++;
			end
			phase_no++;
			if (phase_no % 8 == 0)
				drain_wait();
		end

		// wind down
		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("tb_stack_with_reverse_and_sort passed");
		else
			$display("tb_stack_with_reverse_and_sort failed");
		$finish;
	end

endmodule

`default_nettype wire
